// ===== design/etok_pkg.sv =====
// Shared types, codes and character classes for the expression tokenizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package etok_pkg;

    localparam int POS_W   = 16;
    localparam int LEN_W   = 8;
    localparam int KIND_W  = 4;
    localparam int CHAR_W  = 8;
    localparam int WORD_W  = 32;

    localparam logic [LEN_W-1:0] MAX_TOKEN_LENGTH = 8'd255;
    localparam logic [POS_W-1:0] MAX_POSITION     = 16'hFFFF;

    // result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // scanner modes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_NUMBER = 2'd1;
    localparam logic [1:0] MODE_IDENT  = 2'd2;
    localparam logic [1:0] MODE_ERROR  = 2'd3;

    // token kinds
    localparam logic [KIND_W-1:0] KIND_NUMBER = 4'd0;
    localparam logic [KIND_W-1:0] KIND_IDENT  = 4'd1;
    localparam logic [KIND_W-1:0] KIND_EQUALS = 4'd2;
    localparam logic [KIND_W-1:0] KIND_LPAREN = 4'd3;
    localparam logic [KIND_W-1:0] KIND_RPAREN = 4'd4;
    localparam logic [KIND_W-1:0] KIND_BINOP  = 4'd5;
    localparam logic [KIND_W-1:0] KIND_LET    = 4'd6;
    localparam logic [KIND_W-1:0] KIND_NULL   = 4'd7;
    localparam logic [KIND_W-1:0] KIND_EOF    = 4'd8;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 4'd9;

    localparam logic [WORD_W-1:0] WORD_LET  = 32'h006C_6574;
    localparam logic [WORD_W-1:0] WORD_NULL = 32'h6E75_6C6C;

    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_EQUALS = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_PCT    = 8'h25;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              end_of_source;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0] token_kind;
        logic [POS_W-1:0]  token_start;
        logic [LEN_W-1:0]  token_length;
        logic [CHAR_W-1:0] operator_char;
        logic              last_result;
    } t_result;

    // up to two results produced by one item
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_push;

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

endpackage

// ===== design/etok_scan.sv =====
// Scanner: classifies the registered byte, keeps the open token and position,
// and produces up to two results per item. Depends on etok_pkg.
`timescale 1ns / 1ps

module etok_scan (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  etok_pkg::t_in_item i_item,
    output etok_pkg::t_push   o_push
);
    import etok_pkg::*;

    logic [1:0]        r_mode,      n_mode;
    logic [POS_W-1:0]  r_tok_start, n_tok_start;
    logic [LEN_W-1:0]  r_tok_len,   n_tok_len;
    logic [WORD_W-1:0] r_prefix,    n_prefix;
    logic [POS_W-1:0]  r_pos,       n_pos;

    always_comb begin
        logic [CHAR_W-1:0] c;
        logic              emit_flush;
        logic              second_v;
        logic              cont;
        t_result           flush_res;
        t_result           second;

        c           = i_item.char_code;
        n_mode      = r_mode;
        n_tok_start = r_tok_start;
        n_tok_len   = r_tok_len;
        n_prefix    = r_prefix;
        n_pos       = r_pos;
        second_v    = 1'b0;
        second      = '0;
        emit_flush  = (r_mode == MODE_NUMBER) || (r_mode == MODE_IDENT);
        cont        = ((r_mode == MODE_NUMBER) && is_digit(c)) ||
                      ((r_mode == MODE_IDENT) && is_letter(c));

        flush_res              = '0;
        flush_res.token_start  = r_tok_start;
        flush_res.token_length = r_tok_len;
        if (r_mode == MODE_NUMBER) begin
            flush_res.token_kind = KIND_NUMBER;
        end else if ((r_tok_len == 8'd3) && (r_prefix == WORD_LET)) begin
            flush_res.token_kind = KIND_LET;
        end else if ((r_tok_len == 8'd4) && (r_prefix == WORD_NULL)) begin
            flush_res.token_kind = KIND_NULL;
        end else begin
            flush_res.token_kind = KIND_IDENT;
        end

        if (i_item.end_of_source) begin
            second_v           = 1'b1;
            second.token_kind  = KIND_EOF;
            second.token_start = r_pos;
            n_mode      = MODE_IDLE;
            n_tok_start = '0;
            n_tok_len   = '0;
            n_prefix    = '0;
            n_pos       = '0;
        end else if (r_mode == MODE_ERROR) begin
            emit_flush = 1'b0;
        end else begin
            n_pos = (r_pos == MAX_POSITION) ? '0 : r_pos + 1'b1;
            if (cont) begin
                emit_flush = 1'b0;
                if ((r_mode == MODE_IDENT) && (r_tok_len < 8'd4)) begin
                    n_prefix = {r_prefix[WORD_W-CHAR_W-1:0], c};
                end
                if (r_tok_len < MAX_TOKEN_LENGTH) begin
                    n_tok_len = r_tok_len + 1'b1;
                end
            end else begin
                n_mode              = MODE_IDLE;
                second.token_start  = r_pos;
                second.token_length = 8'd1;
                if ((c == CH_SPACE) || (c == CH_LF) || (c == CH_TAB)) begin
                    second_v = 1'b0;
                end else if (c == CH_LPAREN) begin
                    second_v             = 1'b1;
                    second.token_kind    = KIND_LPAREN;
                    second.operator_char = c;
                end else if (c == CH_RPAREN) begin
                    second_v             = 1'b1;
                    second.token_kind    = KIND_RPAREN;
                    second.operator_char = c;
                end else if (c == CH_EQUALS) begin
                    second_v             = 1'b1;
                    second.token_kind    = KIND_EQUALS;
                    second.operator_char = c;
                end else if (c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT}) begin
                    second_v             = 1'b1;
                    second.token_kind    = KIND_BINOP;
                    second.operator_char = c;
                end else if (is_digit(c) || is_letter(c)) begin
                    n_mode      = is_digit(c) ? MODE_NUMBER : MODE_IDENT;
                    n_tok_start = r_pos;
                    n_tok_len   = 8'd1;
                    n_prefix    = {{(WORD_W-CHAR_W){1'b0}}, c};
                end else begin
                    second_v          = 1'b1;
                    second.token_kind = KIND_ERROR;
                    n_mode            = MODE_ERROR;
                end
            end
        end

        // pack: open token first, then the byte's own result
        if (emit_flush) begin
            o_push.r0  = flush_res;
            o_push.r1  = second;
            o_push.cnt = second_v ? 2'd2 : 2'd1;
        end else begin
            o_push.r0  = second;
            o_push.r1  = second;
            o_push.cnt = {1'b0, second_v};
        end
        o_push.r0.last_result = (o_push.cnt == 2'd1);
        o_push.r1.last_result = 1'b1;
        if (!i_take) begin
            o_push.cnt = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_tok_start <= '0;
            r_tok_len   <= '0;
            r_prefix    <= '0;
            r_pos       <= '0;
        end else if (i_take) begin
            r_mode      <= n_mode;
            r_tok_start <= n_tok_start;
            r_tok_len   <= n_tok_len;
            r_prefix    <= n_prefix;
            r_pos       <= n_pos;
        end
    end

endmodule

// ===== design/etok_queue.sv =====
// Result queue: register file taking up to two results a cycle, one out unless i_stall holds it.
// Depends on etok_pkg.
`timescale 1ns / 1ps

module etok_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  etok_pkg::t_push  i_push,
    output logic             o_room,
    output logic             o_valid,
    output etok_pkg::t_result o_item,
    input  logic             i_stall
);
    import etok_pkg::*;

    t_result           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              pop;

    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign o_room  = (r_cnt <= QCNT_W'(QUEUE_DEPTH - 2));
    assign pop     = o_valid && !i_stall;

    always_comb begin
        n_wr  = r_wr + QPTR_W'(i_push.cnt);
        n_rd  = pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + QCNT_W'(i_push.cnt) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wr + 1'b1] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== design/expression_tokenizer.sv =====
// Top level of the expression tokenizer: input register, scanner, result queue.
// Depends on etok_pkg, etok_scan and etok_queue.
`timescale 1ns / 1ps
//
//  channel  | direction | handshake                       | payload
//  ---------+-----------+---------------------------------+---------------------
//  input    | in        | i_in_valid / o_in_stall         | i_in_item (t_in_item)
//  result   | out       | o_out_valid / i_out_stall       | o_out_item (t_result)
//
//  One byte is taken per cycle while the input is not stalled; a byte closing an open
//  token while giving a token of its own yields two results, which the output sends
//  on separate cycles. o_out_valid rises once a byte has passed the input register
//  and the scanner has written its results into the four-entry result queue.
//  Synchronous active-low reset empties the pipeline and returns scanning to idle.
//  Input stalls only while a registered byte waits for two free queue slots.

module expression_tokenizer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  etok_pkg::t_in_item i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output etok_pkg::t_result  o_out_item
);
    import etok_pkg::*;

    logic     r_in_valid;
    t_in_item r_in_item;
    logic     room;
    logic     take;
    t_push    push;

    assign take       = r_in_valid && room;
    assign o_in_stall = r_in_valid && !room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item <= i_in_item;
        end
    end

    etok_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_item  (r_in_item),
        .o_push  (push)
    );

    etok_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_out_valid),
        .o_item  (o_out_item),
        .i_stall (i_out_stall)
    );

endmodule
